// ----- src/lzod_pkg.sv -----
// Package for the LZO1X stream decompressor: opcodes, parse phases,
// status codes and default sizes. No dependencies.
package lzod_pkg;

	localparam int unsigned DefHistoryDepth = 65536;
	localparam int unsigned DefLengthBits   = 24;
	localparam int unsigned CountBits       = 24;
	localparam int unsigned DistBits        = 17;

	// Item opcodes; the idle code is ignored.
	typedef enum logic [1:0] {
		OP_BYTE  = 2'd0,
		OP_DRAIN = 2'd1,
		OP_START = 2'd2,
		OP_IDLE  = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		PH_FIRST       = 4'd0,
		PH_TOP         = 4'd1,
		PH_AFTER_RUN   = 4'd2,
		PH_AFTER_TRAIL = 4'd3,
		PH_LIT_RUN     = 4'd4,
		PH_LIT_TRAIL   = 4'd5,
		PH_EXT_LIT     = 4'd6,
		PH_EXT_M3      = 4'd7,
		PH_EXT_M4      = 4'd8,
		PH_DIST_LO     = 4'd9,
		PH_DIST_HI     = 4'd10,
		PH_M2_B        = 4'd11,
		PH_M1_B        = 4'd12,
		PH_M1R_B       = 4'd13
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_BUSY      = 3'd1,
		ST_FAR       = 3'd2,
		ST_OVERFLOW  = 3'd3,
		ST_AFTER_END = 3'd4
	} status_t;

endpackage

// ----- src/lzod_ram.sv -----
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module lzod_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Read data registered; a read of the entry written at the same edge
	// returns the old contents.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- src/lzo1x_stream_decompressor.sv -----
// LZO1X stream decompressor: one compressed byte or one copy byte per item.
// Depends on lzod_pkg and lzod_ram.
// Each result passes through the s1 and s2 pipeline registers before it appears.
// Throughput: one item per cycle while res_stall does not hold the output; each item makes one
// history read and a byte-emitting item one history write, on the single read and write port.
// Reset (arst_n low): parse state, counters and pipeline clear at once; the
// history memory is not cleared and needs no clearing pass.
module lzo1x_stream_decompressor
	import lzod_pkg::*;
#(
	parameter int unsigned HISTORY_DEPTH = DefHistoryDepth,
	parameter int unsigned LENGTH_BITS   = DefLengthBits
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [1:0]           opcode,
	input  logic [7:0]           data_byte,
	output logic                 res_valid,
	input  logic                 res_stall,
	output logic [7:0]           out_byte,
	output logic                 out_valid,
	output logic                 need_input,
	output logic                 stream_done,
	output logic [CountBits-1:0] output_count,
	output logic [2:0]           status
);

	localparam int unsigned AW = $clog2(HISTORY_DEPTH);
	localparam int unsigned LB = LENGTH_BITS;
	localparam int unsigned LW = LENGTH_BITS + 2;
	localparam int unsigned DW = ((AW > DistBits) ? AW : DistBits) + 1;
	localparam logic [LW-1:0] LenMax = LW'((64'd1 << LENGTH_BITS) - 64'd1);
	localparam logic [CountBits-1:0] CountMax = '1;

	// Architectural state.
	phase_t               phase_q;
	logic [LB-1:0]        run_q;
	logic [7:0]           held_q;
	logic [DistBits-1:0]  dist_q;
	logic [LB-1:0]        rem_q;
	logic [1:0]           trail_q;
	logic                 fin_q;
	logic [AW-1:0]        wp_q;
	logic [CountBits-1:0] cnt_q;

	phase_t               phase_n;
	logic [LB-1:0]        run_n;
	logic [7:0]           held_n;
	logic [DistBits-1:0]  dist_n;
	logic [LB-1:0]        rem_n;
	logic [1:0]           trail_n;
	logic                 fin_n;
	logic [AW-1:0]        wp_n;
	logic [CountBits-1:0] cnt_n;
	status_t              st_n;
	logic                 lit_n;
	logic                 drain_n;
	logic [AW-1:0]        src_n;

	// Pipeline registers.
	logic                 s1_v, s2_v;
	logic                 s1_wr, s1_lit, s1_fwd;
	logic [7:0]           s1_b;
	logic [AW-1:0]        s1_wa;
	logic                 s1_need, s1_done;
	logic [CountBits-1:0] s1_cnt;
	status_t              s1_st;
	logic [7:0]           s2_byte;
	logic                 s2_ov, s2_need, s2_done;
	logic [CountBits-1:0] s2_cnt;
	status_t              s2_st;
	logic [7:0]           last_wr_q;
	logic [7:0]           rdata;
	logic [7:0]           s1_byte;

	logic                 adv, acc;

	// Helpers for the match start and length sums.
	logic                 sm_go;
	logic [DistBits-1:0]  sm_dist;
	logic [LB-1:0]        sm_len;
	logic [1:0]           sm_trail;
	logic [LW-1:0]        sum;
	logic [13:0]          d14;
	logic [DistBits-1:0]  d_m4;
	logic [DW-1:0]        diff;
	logic                 top_code;

	assign adv      = !(s2_v && res_stall);
	assign in_stall = !adv;
	assign acc      = in_valid && adv;

	// Next state for one accepted transaction.
	always_comb begin
		phase_n  = phase_q;
		run_n    = run_q;
		held_n   = held_q;
		dist_n   = dist_q;
		rem_n    = rem_q;
		trail_n  = trail_q;
		fin_n    = fin_q;
		wp_n     = wp_q;
		cnt_n    = cnt_q;
		st_n     = ST_OK;
		lit_n    = 1'b0;
		drain_n  = 1'b0;
		sm_go    = 1'b0;
		sm_dist  = '0;
		sm_len   = '0;
		sm_trail = '0;
		sum      = '0;
		d14      = '0;
		d_m4     = '0;
		top_code = 1'b0;
		diff     = DW'(wp_q) - DW'(dist_q);
		if (diff[DW-1]) begin
			diff = diff + DW'(HISTORY_DEPTH);
		end
		src_n = diff[AW-1:0];
		case (op_t'(opcode))
			OP_BYTE: begin
				if (fin_q) begin
					st_n = ST_AFTER_END;
				end else if (rem_q != '0) begin
					st_n = ST_BUSY;
				end else begin
					top_code = (phase_q == PH_TOP) ||
						(phase_q == PH_FIRST && data_byte <= 8'd17);
					if (phase_q == PH_FIRST && data_byte > 8'd17) begin
						if (data_byte - 8'd17 < 8'd4) begin
							trail_n = 2'(data_byte - 8'd17);
							phase_n = PH_LIT_TRAIL;
						end else begin
							run_n   = LB'(data_byte - 8'd17);
							phase_n = PH_LIT_RUN;
						end
					end else if (top_code || ((phase_q == PH_AFTER_RUN ||
							phase_q == PH_AFTER_TRAIL) && data_byte >= 8'd16)) begin
						if (data_byte >= 8'd16) begin
							// Match code byte.
							held_n = data_byte;
							run_n  = '0;
							if (data_byte >= 8'd64) begin
								phase_n = PH_M2_B;
							end else if (data_byte >= 8'd32) begin
								if (data_byte[4:0] == 5'd0) begin
									phase_n = PH_EXT_M3;
								end else begin
									run_n   = LB'(data_byte[4:0]) + LB'(2);
									phase_n = PH_DIST_LO;
								end
							end else if (data_byte[2:0] == 3'd0) begin
								phase_n = PH_EXT_M4;
							end else begin
								run_n   = LB'(data_byte[2:0]) + LB'(2);
								phase_n = PH_DIST_LO;
							end
						end else if (data_byte == 8'd0) begin
							run_n   = '0;
							phase_n = PH_EXT_LIT;
						end else begin
							run_n   = LB'(data_byte) + LB'(3);
							phase_n = PH_LIT_RUN;
						end
					end else begin
						case (phase_q)
							PH_AFTER_RUN: begin
								held_n  = data_byte;
								phase_n = PH_M1R_B;
							end
							PH_AFTER_TRAIL: begin
								held_n  = data_byte;
								phase_n = PH_M1_B;
							end
							PH_LIT_RUN: begin
								lit_n = 1'b1;
								if (run_q <= LB'(1)) begin
									run_n   = '0;
									phase_n = PH_AFTER_RUN;
								end else begin
									run_n = run_q - LB'(1);
								end
							end
							PH_LIT_TRAIL: begin
								lit_n = 1'b1;
								if (trail_q <= 2'd1) begin
									trail_n = '0;
									phase_n = PH_AFTER_TRAIL;
								end else begin
									trail_n = trail_q - 2'd1;
								end
							end
							PH_EXT_LIT, PH_EXT_M3, PH_EXT_M4: begin
								if (data_byte == 8'd0) begin
									sum = LW'(run_q) + LW'(255);
								end else if (phase_q == PH_EXT_LIT) begin
									sum     = LW'(run_q) + LW'(data_byte) + LW'(18);
									phase_n = PH_LIT_RUN;
								end else begin
									sum = LW'(run_q) + LW'(data_byte) +
										((phase_q == PH_EXT_M3) ? LW'(33) : LW'(9));
									phase_n = PH_DIST_LO;
								end
								if (sum > LenMax) begin
									st_n  = ST_OVERFLOW;
									run_n = LenMax[LB-1:0];
								end else begin
									run_n = sum[LB-1:0];
								end
							end
							PH_DIST_LO: begin
								dist_n  = DistBits'(data_byte);
								phase_n = PH_DIST_HI;
							end
							PH_DIST_HI: begin
								d14 = 14'({data_byte, dist_q[7:0]} >> 2);
								if (held_q >= 8'd32) begin
									sm_go   = 1'b1;
									sm_dist = DistBits'(d14) + DistBits'(1);
								end else begin
									d_m4 = DistBits'(d14) +
										(held_q[3] ? DistBits'(16384) : '0);
									if (d_m4 == '0) begin
										// End of stream code.
										fin_n   = 1'b1;
										rem_n   = '0;
										trail_n = '0;
										phase_n = PH_TOP;
									end else begin
										sm_go   = 1'b1;
										sm_dist = d_m4 + DistBits'(16384);
									end
								end
								sm_len   = run_q;
								sm_trail = dist_q[1:0];
							end
							PH_M2_B: begin
								sm_go    = 1'b1;
								sm_dist  = DistBits'(1) + DistBits'(held_q[4:2]) +
									(DistBits'(data_byte) << 3);
								sm_len   = LB'(held_q[7:5]) + LB'(1);
								sm_trail = held_q[1:0];
							end
							PH_M1_B: begin
								sm_go    = 1'b1;
								sm_dist  = DistBits'(1) + DistBits'(held_q[7:2]) +
									(DistBits'(data_byte) << 2);
								sm_len   = LB'(2);
								sm_trail = held_q[1:0];
							end
							PH_M1R_B: begin
								sm_go    = 1'b1;
								sm_dist  = DistBits'(1 + 2048) + DistBits'(held_q[7:2]) +
									(DistBits'(data_byte) << 2);
								sm_len   = LB'(3);
								sm_trail = held_q[1:0];
							end
							default: begin
								phase_n = PH_TOP;
							end
						endcase
					end
					// Load a pending copy unless it reaches before the stream.
					if (sm_go) begin
						trail_n = sm_trail;
						if (CountBits'(sm_dist) > cnt_q) begin
							st_n  = ST_FAR;
							rem_n = '0;
						end else begin
							dist_n = sm_dist;
							rem_n  = sm_len;
						end
						phase_n = (sm_trail != 2'd0) ? PH_LIT_TRAIL : PH_TOP;
					end
				end
			end
			OP_DRAIN: begin
				if (rem_q != '0 && !fin_q) begin
					drain_n = 1'b1;
					rem_n   = rem_q - LB'(1);
				end
			end
			OP_START: begin
				cnt_n   = '0;
				phase_n = PH_FIRST;
				run_n   = '0;
				held_n  = '0;
				dist_n  = '0;
				rem_n   = '0;
				trail_n = '0;
				fin_n   = 1'b0;
			end
			default: begin
			end
		endcase
		// Every emitted byte advances the history position and the count; the count saturates at its maximum.
		if (lit_n || drain_n) begin
			wp_n = (wp_q == AW'(HISTORY_DEPTH - 1)) ? '0 : wp_q + AW'(1);
			if (cnt_q != CountMax) begin
				cnt_n = cnt_q + CountBits'(1);
			end
		end
	end

	// State registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_FIRST;
			run_q   <= '0;
			held_q  <= '0;
			dist_q  <= '0;
			rem_q   <= '0;
			trail_q <= '0;
			fin_q   <= 1'b0;
			wp_q    <= '0;
			cnt_q   <= '0;
		end else if (acc) begin
			phase_q <= phase_n;
			run_q   <= run_n;
			held_q  <= held_n;
			dist_q  <= dist_n;
			rem_q   <= rem_n;
			trail_q <= trail_n;
			fin_q   <= fin_n;
			wp_q    <= wp_n;
			cnt_q   <= cnt_n;
		end
	end

	// History memory: read when an item enters stage 1, write when an item that emits a byte leaves it.
	lzod_ram #(
		.WIDTH(8),
		.DEPTH(HISTORY_DEPTH)
	) u_history (
		.clk  (clk),
		.we   (adv && s1_v && s1_wr),
		.waddr(s1_wa),
		.wdata(s1_byte),
		.re   (adv),
		.raddr(src_n),
		.rdata(rdata)
	);

	// A copy reading the entry written at the same edge takes the forwarded byte.
	assign s1_byte = s1_lit ? s1_b : (s1_fwd ? last_wr_q : rdata);

	// Pipeline valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v <= 1'b0;
			s2_v <= 1'b0;
		end else if (adv) begin
			s1_v <= acc;
			s2_v <= s1_v;
		end
	end

	// Pipeline payload.
	always_ff @(posedge clk) begin
		if (adv) begin
			s1_wr   <= acc && (lit_n || drain_n);
			s1_lit  <= lit_n;
			s1_fwd  <= drain_n && s1_v && s1_wr && (s1_wa == src_n);
			s1_b    <= data_byte;
			s1_wa   <= wp_q;
			s1_need <= (rem_n == '0) && !fin_n;
			s1_done <= fin_n;
			s1_cnt  <= cnt_n;
			s1_st   <= st_n;
			s2_byte <= s1_wr ? s1_byte : 8'd0;
			s2_ov   <= s1_wr;
			s2_need <= s1_need;
			s2_done <= s1_done;
			s2_cnt  <= s1_cnt;
			s2_st   <= s1_st;
			if (s1_v && s1_wr) begin
				last_wr_q <= s1_byte;
			end
		end
	end

	assign res_valid    = s2_v;
	assign out_byte     = s2_byte;
	assign out_valid    = s2_ov;
	assign need_input   = s2_need;
	assign stream_done  = s2_done;
	assign output_count = s2_cnt;
	assign status       = s2_st;

	// A finished stream never holds a pending copy.
	a_fin_no_copy: assert property (@(posedge clk) disable iff (!arst_n)
		fin_q |-> rem_q == '0)
		else $error("pending copy after end of stream");

	// Forwarding is only ever selected for a copy byte.
	a_fwd_copy_only: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_v && s1_fwd) |-> (s1_wr && !s1_lit))
		else $error("forwarding selected for a non-copy item");

	// The history position moves only together with an emitted byte.
	a_wp_step: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && !(lit_n || drain_n)) |=> $stable(wp_q))
		else $error("history position moved without a byte");

	// A held result stays unchanged while the output is stalled.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(s2_v && res_stall) |=> ($stable(s2_byte) && $stable(s2_cnt)))
		else $error("stalled result changed");

endmodule
